### sv/ttd_pkg.sv
// Shared types, constants and tables for the turn-then-drive command sequencer.
`default_nettype none
package ttd_pkg;

  // Default geometry and iteration count.
  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 768;
  localparam int DEF_CORDIC_STEPS  = 16;

  // CORDIC table size and iteration counter width.
  localparam int MAX_STEPS = 24;
  localparam int STEP_W    = 5;

  // CORDIC vector width (covers the largest screen and pose offsets).
  localparam int CW = 36;

  // Reciprocal of the CORDIC gain, Q30.
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

  // Port widths.
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Divider geometry.
  localparam int DIV_W  = 33;
  localparam int DVS_W  = 24;
  localparam int DCNT_W = 6;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Drive commands.
  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_LEFT    = 2'd2;
  localparam logic [1:0] CMD_RIGHT   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_PIXEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_TICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_TICK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS     = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic tick;
    logic capture;
    logic map;
    logic init;
    logic step;
    logic mul;
    logic fin;
    logic div_start;
    logic div_turn;
    logic lat_tf;
    logic load;
  } ttd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic area_ok;
    logic cord_last;
    logic too_close;
    logic div_busy;
  } ttd_sts_t;

  // Arctangent of 2^-i as a 32 bit turn fraction.
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/turn_then_drive_command_sequencer_top.sv
// Top level of the turn-then-drive command sequencer.
//
// Input items arrive on the in_ stream; in_tuser selects a click (0) or a tick (1).
// A click carries a screen point and the robot pose. Clicks outside the upper-right
// quarter, or on targets within robot_radius, change nothing. Other clicks load a
// four-slot plan: stop, turn, forward, stop. Clicks give no output item.
// Each tick gives one output item on the out_ stream with the next drive command.
// A tick's command is in the output register on the next cycle. A click runs through
// capture, mapping, one CORDIC rotation per cycle, scaling and checks, and then two
// passes (33 quotient bits and a hand-off each) through the shared serial divider.
// Clicks that miss the accepted area end after mapping, targets too close after the
// checks. Items are taken one at a time. When the receiver stalls, the command waits
// in the output register and a new input item is taken only once the register is
// free or being emptied. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata only while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) restores register defaults and an empty plan;
// the first tick after reset emits stop.
`default_nettype none
module turn_then_drive_command_sequencer_top #(
  parameter int SCREEN_WIDTH  = ttd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = ttd_pkg::DEF_SCREEN_HEIGHT,
  parameter int CORDIC_STEPS  = ttd_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // click_x[9:0], click_y[19:10], robot_x[45:20], robot_y[71:46], robot_heading[87:72]
  input  wire logic [ttd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // command[1:0], zero fill above
  output logic [ttd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [ttd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ttd_pkg::*;

  ttd_cmd_t   cmd;
  ttd_sts_t   sts;
  logic [1:0] tick_cmd;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_cmd_r;

  assign out_free = !out_valid_r || out_tready;

  ttd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttd_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .tick_cmd  (tick_cmd)
  );

  // Output register holds one command item until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      out_cmd_r <= tick_cmd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_cmd_r};
endmodule
`default_nettype wire

### sv/ttd_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module ttd_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ttd_pkg::DIV_W-1:0] dividend,
  input  wire logic [ttd_pkg::DVS_W-1:0] divisor,
  output logic                           busy,
  output logic [ttd_pkg::DIV_W-1:0]      quotient
);
  import ttd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    sh;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // One trial subtraction of the shifted remainder.
  assign sh   = {rem_r[DVS_W-1:0], quo_r[DIV_W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs_r};
  assign ge   = !diff[DVS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W:0] : sh;
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand registers need no reset.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

### sv/ttd_ctrl.sv
// Controller state machine that sequences clicks and ticks.
`default_nettype none
module ttd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_op,
  input  wire logic             out_free,
  output logic                  in_tready,
  output ttd_pkg::ttd_cmd_t     cmd,
  input  wire ttd_pkg::ttd_sts_t sts
);
  import ttd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAP  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_CORD = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DIVF = 4'd7;
  localparam logic [3:0] S_DIVT = 4'd8;

  logic [3:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE) && out_free;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_op) begin
            cmd.tick = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_MAP;
          end
        end
      end
      S_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = sts.area_ok ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.step = 1'b1;
        if (sts.cord_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.too_close) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVF;
        end
      end
      S_DIVF: begin
        if (!sts.div_busy) begin
          cmd.lat_tf    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_turn  = 1'b1;
          state_nxt     = S_DIVT;
        end
      end
      S_DIVT: begin
        if (!sts.div_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/ttd_dp.sv
// Datapath: configuration, coordinate mapping, CORDIC, scaling, division and slots.
`default_nettype none
module ttd_dp #(
  parameter int SCREEN_WIDTH  = ttd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = ttd_pkg::DEF_SCREEN_HEIGHT,
  parameter int CORDIC_STEPS  = ttd_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ttd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [ttd_pkg::IN_TDATA_W-1:0] in_data,
  input  wire ttd_pkg::ttd_cmd_t              cmd,
  output ttd_pkg::ttd_sts_t                   sts,
  output logic [1:0]                          tick_cmd
);
  import ttd_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam logic signed [15:0] W3 = 16'(3 * SCREEN_WIDTH);
  localparam logic signed [15:0] HH = 16'(SCREEN_HEIGHT);

  // Configuration registers.
  logic [15:0] mm_r;
  logic [23:0] radius_r, stopd_r, speed_r;
  logic [13:0] turn_r;
  logic [15:0] stopt_r;

  // Captured click.
  logic [9:0]         cx_r, cy_r;
  logic signed [25:0] rx_r, ry_r;
  logic [15:0]        hd_r;

  // Mapping and CORDIC.
  logic signed [15:0]   dx, dy;
  logic signed [16:0]   mm_s;
  logic signed [32:0]   px, py;
  logic signed [32:0]   wx_r, wy_r;
  logic signed [CW-1:0] x0, y0, x_r, y_r, xs, ys;
  logic [31:0]          z_r, zr;
  logic [STEP_W-1:0]    i_r;

  // Scaling and bearing.
  logic [32:0]        xm;
  logic [62:0]        prod_r, psum;
  logic [32:0]        dist_r;
  logic signed [34:0] rem;
  logic [15:0]        bearing, err, mag_r;
  logic [1:0]         dir_r;
  logic [15:0]        tf_r, tr;

  // Divider link.
  logic [DIV_W-1:0] div_dividend, quo;
  logic [DVS_W-1:0] div_divisor;
  logic             div_busy;

  // Slot line: stage 0 is the current slot, later stages the lower slots.
  logic               started_r, started_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [1:0]         stg_cmd_r [4];
  logic [1:0]         stg_cmd_nxt [4];
  logic signed [17:0] stg_tk_r [4];
  logic signed [17:0] stg_tk_nxt [4];
  logic               cur_le0;

  // Screen point to world offsets.
  assign dx   = $signed({4'b0000, cx_r, 2'b00}) - W3;
  assign dy   = HH - $signed({4'b0000, cy_r, 2'b00});
  assign mm_s = $signed({1'b0, mm_r});
  assign px   = dx * mm_s;
  assign py   = dy * mm_s;

  assign sts.area_ok = ({2'b00, cx_r, 1'b0} >= 13'(SCREEN_WIDTH)) &&
                       ({2'b00, cy_r, 1'b0} <= 13'(SCREEN_HEIGHT));

  // Vector from robot to target.
  assign x0 = CW'(wx_r) - CW'(rx_r);
  assign y0 = CW'(wy_r) - CW'(ry_r);

  // One CORDIC rotation.
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign sts.cord_last = (i_r == STEP_W'(NSTEPS - 1));

  // Magnitude scaling and rounding.
  assign xm   = x_r[CW-1] ? '0 : x_r[32:0];
  assign psum = prod_r + 63'(1 << 29);

  // Bearing error, rounded to 16 bits.
  assign zr      = z_r + 32'h0000_8000;
  assign bearing = zr[31:16];
  assign err     = bearing - hd_r;

  // Travel left after braking.
  assign rem = $signed({2'b00, dist_r}) - $signed({10'b0, stopd_r, 1'b0});
  assign sts.too_close = (dist_r <= {9'b0, radius_r});

  // Divider operands.
  assign div_dividend = cmd.div_turn ? {17'b0, mag_r} : rem[DIV_W-1:0];
  assign div_divisor  = cmd.div_turn ? {10'b0, turn_r} : speed_r;
  assign sts.div_busy = div_busy;
  assign tr           = (turn_r == '0) ? TICK_MAX : quo[15:0];

  ttd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Tick handling and slot loading.
  assign cur_le0 = stg_tk_r[0][17] || (stg_tk_r[0] == '0);

  always_comb begin
    started_nxt = started_r;
    idx_nxt     = idx_r;
    stg_cmd_nxt = stg_cmd_r;
    stg_tk_nxt  = stg_tk_r;
    tick_cmd    = CMD_STOP;
    if (cmd.tick) begin
      if (!started_r) begin
        started_nxt = 1'b1;
      end else if (cur_le0) begin
        if (idx_r != 2'd0) begin
          stg_cmd_nxt[0] = stg_cmd_r[1];
          stg_cmd_nxt[1] = stg_cmd_r[2];
          stg_cmd_nxt[2] = stg_cmd_r[3];
          stg_tk_nxt[0]  = stg_tk_r[1][17] ? stg_tk_r[1] : stg_tk_r[1] - 18'sd1;
          stg_tk_nxt[1]  = stg_tk_r[2];
          stg_tk_nxt[2]  = stg_tk_r[3];
          idx_nxt        = idx_r - 2'd1;
          tick_cmd       = stg_cmd_r[1];
        end
      end else begin
        stg_tk_nxt[0] = stg_tk_r[0] - 18'sd1;
        tick_cmd      = stg_cmd_r[0];
      end
    end else if (cmd.load) begin
      stg_cmd_nxt[0] = CMD_STOP;
      stg_tk_nxt[0]  = $signed({2'b00, stopt_r});
      stg_cmd_nxt[1] = dir_r;
      stg_tk_nxt[1]  = $signed({2'b00, tr});
      stg_cmd_nxt[2] = CMD_FORWARD;
      stg_tk_nxt[2]  = $signed({2'b00, tf_r});
      stg_cmd_nxt[3] = CMD_STOP;
      stg_tk_nxt[3]  = $signed({2'b00, stopt_r});
      idx_nxt        = 2'd3;
    end
  end

  // Control state, slot line and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      idx_r        <= 2'd0;
      stg_cmd_r[0] <= CMD_STOP;
      stg_tk_r[0]  <= '0;
      mm_r         <= 16'd256;
      radius_r     <= 24'd38400;
      stopd_r      <= '0;
      speed_r      <= 24'd256;
      turn_r       <= 14'd182;
      stopt_r      <= '0;
    end else begin
      started_r <= started_nxt;
      idx_r     <= idx_nxt;
      stg_cmd_r <= stg_cmd_nxt;
      stg_tk_r  <= stg_tk_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MM_PER_PIXEL:   mm_r     <= cfg_wdata[15:0];
          REG_ROBOT_RADIUS:   radius_r <= cfg_wdata;
          REG_STOP_DISTANCE:  stopd_r  <= cfg_wdata;
          REG_SPEED_PER_TICK: speed_r  <= cfg_wdata;
          REG_TURN_PER_TICK:  turn_r   <= cfg_wdata[13:0];
          REG_STOP_TICKS:     stopt_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Click payload pipeline.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r <= in_data[9:0];
      cy_r <= in_data[19:10];
      rx_r <= $signed(in_data[45:20]);
      ry_r <= $signed(in_data[71:46]);
      hd_r <= in_data[87:72];
    end
    if (cmd.map) begin
      wx_r <= px >>> 2;
      wy_r <= py >>> 2;
    end
    if (cmd.init) begin
      i_r <= '0;
      if (x0 < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= 32'h8000_0000;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (cmd.step) begin
      i_r <= i_r + 1'b1;
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_turn(i_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_turn(i_r);
      end
    end
    if (cmd.mul) begin
      prod_r <= 63'(xm) * 63'(INV_GAIN_Q30);
    end
    if (cmd.fin) begin
      dist_r <= psum[62:30];
      if (err > 16'h8000) begin
        dir_r <= CMD_RIGHT;
        mag_r <= 16'(17'h10000 - {1'b0, err});
      end else begin
        dir_r <= CMD_LEFT;
        mag_r <= err;
      end
    end
    if (cmd.lat_tf) begin
      if (rem <= 0) begin
        tf_r <= '0;
      end else if ((speed_r == '0) || (quo[DIV_W-1:16] != '0)) begin
        tf_r <= TICK_MAX;
      end else begin
        tf_r <= quo[15:0];
      end
    end
  end
endmodule
`default_nettype wire

### sv/ttd_chk.sv
// Port-level checks for the command sequencer, bound to the top level.
`default_nettype none
module ttd_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic in_tuser,
  input wire logic out_tvalid,
  input wire logic out_tready
);
  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  // Every accepted tick gives a result on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tvalid)
    else $error("tick item gave no result");

  // A click never creates a result.
  a_click_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !(out_tvalid && !out_tready) |=> !out_tvalid)
    else $error("click item gave a result");

  // A click keeps the input closed while it is worked on.
  a_click_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("input taken during click processing");
endmodule

bind turn_then_drive_command_sequencer_top ttd_chk u_chk (.*);
`default_nettype wire
